// File: rtl/i2cwr_pkg.sv
// Shared types and codes for the I2C write-then-read sequencer.
package i2cwr_pkg;

    // Largest number of write bytes one transaction carries.
    localparam logic [2:0] MAX_WRITE_BYTES = 3'd4;

    // Operation codes.
    localparam logic OP_BEGIN = 1'b0;
    localparam logic OP_EVENT = 1'b1;

    // Bus command codes.
    localparam logic [2:0] CMD_NONE      = 3'd0;
    localparam logic [2:0] CMD_START     = 3'd1;
    localparam logic [2:0] CMD_SEND      = 3'd2;
    localparam logic [2:0] CMD_RECV_ACK  = 3'd3;
    localparam logic [2:0] CMD_RECV_NACK = 3'd4;
    localparam logic [2:0] CMD_STOP      = 3'd5;

    // Outcome codes.
    localparam logic [1:0] ERR_NONE  = 2'd0;
    localparam logic [1:0] ERR_NAK   = 2'd1;
    localparam logic [1:0] ERR_UNEXP = 2'd2;

    // TWI status codes (masked with 0xf8).
    localparam logic [7:0] ST_START      = 8'h08;
    localparam logic [7:0] ST_RSTART     = 8'h10;
    localparam logic [7:0] ST_SLAW_ACK   = 8'h18;
    localparam logic [7:0] ST_SLAW_NAK   = 8'h20;
    localparam logic [7:0] ST_DATAW_ACK  = 8'h28;
    localparam logic [7:0] ST_DATAW_NAK  = 8'h30;
    localparam logic [7:0] ST_SLAR_ACK   = 8'h40;
    localparam logic [7:0] ST_SLAR_NAK   = 8'h48;
    localparam logic [7:0] ST_DATAR_ACK  = 8'h50;
    localparam logic [7:0] ST_DATAR_NACK = 8'h58;
    localparam logic [7:0] ST_MASK       = 8'hf8;

    // Configuration register indexes.
    localparam logic REG_SLAVE_ADDRESS = 1'b0;

    typedef struct packed {
        logic        operation;
        logic [2:0]  write_count;
        logic [31:0] write_data;
        logic [7:0]  read_count;
        logic [7:0]  bus_status;
        logic [7:0]  bus_data;
    } t_item;

    typedef struct packed {
        logic [2:0] bus_command;
        logic [7:0] bus_byte;
        logic       read_valid;
        logic [7:0] read_byte;
        logic       done_res;
        logic [1:0] error_kind;
        logic [7:0] failing_code;
    } t_result;

endpackage

// File: rtl/i2c_write_then_read_sequencer_core.sv
// Top level of the I2C write-then-read sequencer: word registers, APB port, state machine.
//
//   channel  direction  handshake                    payload
//   in       to core    i_in_valid / o_in_ready      i_operation .. i_bus_data
//   out      from core  o_out_valid / i_out_ready    o_bus_command .. o_failing_code
//   cfg      to core    psel, penable, pwrite, pready paddr, pwdata, prdata
//
// Each input word is captured in an input register; the state machine then
// decides its reply, which lands in the result register while the state
// updates. One word per cycle sustained while the output does not stall;
// each word passes the input register and then the result register.
// Reset (synchronous, active low) empties both registers, sets the phase idle
// and the slave address to 0x10. A stall on the output holds the input stage;
// the input register frees as soon as its word moves to the result register.
module i2c_write_then_read_sequencer_core
    import i2cwr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,

    // input words
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_operation,
    input  logic [2:0]  i_write_count,
    input  logic [31:0] i_write_data,
    input  logic [7:0]  i_read_count,
    input  logic [7:0]  i_bus_status,
    input  logic [7:0]  i_bus_data,

    // result words
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [2:0]  o_bus_command,
    output logic [7:0]  o_bus_byte,
    output logic        o_read_valid,
    output logic [7:0]  o_read_byte,
    output logic        o_done_res,
    output logic [1:0]  o_error_kind,
    output logic [7:0]  o_failing_code,

    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // input stage
    logic    r_in_valid;
    t_item   r_item;
    // result stage
    logic    r_out_valid;
    t_result r_res;
    // slave address register
    logic [6:0] r_slave_address;

    logic    w_advance;
    logic    w_in_fire;
    t_result w_res;

    // the word in the input register moves on when the result register is free
    assign w_advance  = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_advance;
    assign w_in_fire  = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_item.operation   <= i_operation;
            r_item.write_count <= i_write_count;
            r_item.write_data  <= i_write_data;
            r_item.read_count  <= i_read_count;
            r_item.bus_status  <= i_bus_status;
            r_item.bus_data    <= i_bus_data;
        end
    end

    i2cwr_fsm u_fsm (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_step          (w_advance),
        .i_item          (r_item),
        .i_slave_address (r_slave_address),
        .o_result        (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_res <= w_res;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_bus_command  = r_res.bus_command;
    assign o_bus_byte     = r_res.bus_byte;
    assign o_read_valid   = r_res.read_valid;
    assign o_read_byte    = r_res.read_byte;
    assign o_done_res     = r_res.done_res;
    assign o_error_kind   = r_res.error_kind;
    assign o_failing_code = r_res.failing_code;

    // APB: pready is tied high; register index is word address bit 2
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slave_address <= 7'h10;
        end else if (psel && penable && pwrite && pready &&
                     paddr[2] == REG_SLAVE_ADDRESS) begin
            r_slave_address <= pwdata[6:0];
        end
    end

    assign prdata = (paddr[2] == REG_SLAVE_ADDRESS) ? {25'd0, r_slave_address} : 32'd0;

endmodule

// File: rtl/i2cwr_fsm.sv
// Transaction state machine: holds the sequencer state and decides each word's reply.
module i2cwr_fsm
    import i2cwr_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_step,
    input  t_item         i_item,
    input  logic [6:0]    i_slave_address,
    output t_result       o_result
);

    localparam logic [3:0] PH_IDLE    = 4'd0;
    localparam logic [3:0] PH_W_START = 4'd1;
    localparam logic [3:0] PH_W_ADDR  = 4'd2;
    localparam logic [3:0] PH_W_DATA  = 4'd3;
    localparam logic [3:0] PH_R_START = 4'd4;
    localparam logic [3:0] PH_R_ADDR  = 4'd5;
    localparam logic [3:0] PH_R_ACK   = 4'd6;
    localparam logic [3:0] PH_R_NACK  = 4'd7;

    logic [3:0]  r_phase, n_phase;
    logic [2:0]  r_writes_left, n_writes_left;
    logic [7:0]  r_reads_left, n_reads_left;
    logic [31:0] r_write_shift, n_write_shift;
    logic        r_did_write, n_did_write;

    logic [7:0] w_status;
    logic [7:0] w_addr;
    logic [2:0] w_wc;
    logic [7:0] w_reads_dec;
    logic [7:0] w_rstart_code;
    t_result    w_res;

    assign w_status      = i_item.bus_status & ST_MASK;
    assign w_addr        = {i_slave_address, 1'b0};
    assign w_wc          = (i_item.write_count > MAX_WRITE_BYTES) ? MAX_WRITE_BYTES
                                                                  : i_item.write_count;
    assign w_reads_dec   = r_reads_left - 8'd1;
    assign w_rstart_code = r_did_write ? ST_RSTART : ST_START;

    always_comb begin
        n_phase       = r_phase;
        n_writes_left = r_writes_left;
        n_reads_left  = r_reads_left;
        n_write_shift = r_write_shift;
        n_did_write   = r_did_write;
        w_res         = '0;

        if (i_item.operation == OP_BEGIN) begin
            n_writes_left = w_wc;
            n_reads_left  = i_item.read_count;
            n_write_shift = i_item.write_data;
            if (w_wc != 3'd0) begin
                n_did_write       = 1'b1;
                w_res.bus_command = CMD_START;
                n_phase           = PH_W_START;
            end else if (i_item.read_count != 8'd0) begin
                n_did_write       = 1'b0;
                w_res.bus_command = CMD_START;
                n_phase           = PH_R_START;
            end else begin
                // empty transaction: done at once
                n_did_write    = 1'b0;
                w_res.done_res = 1'b1;
                n_phase        = PH_IDLE;
            end
        end else begin
            case (r_phase)
                PH_W_START: begin
                    if (w_status == ST_START) begin
                        w_res.bus_command = CMD_SEND;
                        w_res.bus_byte    = w_addr;
                        n_phase           = PH_W_ADDR;
                    end else begin
                        w_res.done_res     = 1'b1;
                        w_res.error_kind   = ERR_UNEXP;
                        w_res.failing_code = w_status;
                        n_phase            = PH_IDLE;
                    end
                end
                PH_W_ADDR, PH_W_DATA: begin
                    if ((r_phase == PH_W_ADDR && w_status == ST_SLAW_ACK) ||
                        (r_phase == PH_W_DATA && w_status == ST_DATAW_ACK &&
                         r_writes_left != 3'd0)) begin
                        w_res.bus_command = CMD_SEND;
                        w_res.bus_byte    = r_write_shift[7:0];
                        n_write_shift     = {8'd0, r_write_shift[31:8]};
                        n_writes_left     = r_writes_left - 3'd1;
                        n_phase           = PH_W_DATA;
                    end else if (r_phase == PH_W_DATA && w_status == ST_DATAW_ACK) begin
                        if (r_reads_left != 8'd0) begin
                            w_res.bus_command = CMD_START;
                            n_phase           = PH_R_START;
                        end else begin
                            w_res.bus_command = CMD_STOP;
                            w_res.done_res    = 1'b1;
                            n_phase           = PH_IDLE;
                        end
                    end else if ((r_phase == PH_W_ADDR && w_status == ST_SLAW_NAK) ||
                                 (r_phase == PH_W_DATA && w_status == ST_DATAW_NAK)) begin
                        w_res.bus_command  = CMD_STOP;
                        w_res.done_res     = 1'b1;
                        w_res.error_kind   = ERR_NAK;
                        w_res.failing_code = w_status;
                        n_phase            = PH_IDLE;
                    end else begin
                        w_res.done_res     = 1'b1;
                        w_res.error_kind   = ERR_UNEXP;
                        w_res.failing_code = w_status;
                        n_phase            = PH_IDLE;
                    end
                end
                PH_R_START: begin
                    if (w_status == w_rstart_code) begin
                        w_res.bus_command = CMD_SEND;
                        w_res.bus_byte    = w_addr | 8'd1;
                        n_phase           = PH_R_ADDR;
                    end else begin
                        w_res.done_res     = 1'b1;
                        w_res.error_kind   = ERR_UNEXP;
                        w_res.failing_code = w_status;
                        n_phase            = PH_IDLE;
                    end
                end
                PH_R_ADDR: begin
                    if (w_status == ST_SLAR_ACK) begin
                        if (r_reads_left > 8'd1) begin
                            w_res.bus_command = CMD_RECV_ACK;
                            n_phase           = PH_R_ACK;
                        end else begin
                            w_res.bus_command = CMD_RECV_NACK;
                            n_phase           = PH_R_NACK;
                        end
                    end else if (w_status == ST_SLAR_NAK) begin
                        w_res.bus_command  = CMD_STOP;
                        w_res.done_res     = 1'b1;
                        w_res.error_kind   = ERR_NAK;
                        w_res.failing_code = w_status;
                        n_phase            = PH_IDLE;
                    end else begin
                        w_res.done_res     = 1'b1;
                        w_res.error_kind   = ERR_UNEXP;
                        w_res.failing_code = w_status;
                        n_phase            = PH_IDLE;
                    end
                end
                PH_R_ACK: begin
                    if (w_status == ST_DATAR_ACK) begin
                        w_res.read_valid = 1'b1;
                        w_res.read_byte  = i_item.bus_data;
                        n_reads_left     = w_reads_dec;
                        // decide on the count left after this byte
                        if (w_reads_dec > 8'd1) begin
                            w_res.bus_command = CMD_RECV_ACK;
                            n_phase           = PH_R_ACK;
                        end else begin
                            w_res.bus_command = CMD_RECV_NACK;
                            n_phase           = PH_R_NACK;
                        end
                    end else begin
                        w_res.done_res     = 1'b1;
                        w_res.error_kind   = ERR_UNEXP;
                        w_res.failing_code = w_status;
                        n_phase            = PH_IDLE;
                    end
                end
                PH_R_NACK: begin
                    if (w_status == ST_DATAR_NACK) begin
                        w_res.read_valid  = 1'b1;
                        w_res.read_byte   = i_item.bus_data;
                        n_reads_left      = 8'd0;
                        w_res.bus_command = CMD_STOP;
                        w_res.done_res    = 1'b1;
                        n_phase           = PH_IDLE;
                    end else begin
                        w_res.done_res     = 1'b1;
                        w_res.error_kind   = ERR_UNEXP;
                        w_res.failing_code = w_status;
                        n_phase            = PH_IDLE;
                    end
                end
                default: begin
                    // event while idle: all-zero reply
                    n_phase = PH_IDLE;
                end
            endcase
        end
    end

    assign o_result = w_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_IDLE;
            r_writes_left <= 3'd0;
            r_reads_left  <= 8'd0;
            r_write_shift <= 32'd0;
            r_did_write   <= 1'b0;
        end else if (i_step) begin
            r_phase       <= n_phase;
            r_writes_left <= n_writes_left;
            r_reads_left  <= n_reads_left;
            r_write_shift <= n_write_shift;
            r_did_write   <= n_did_write;
        end
    end

endmodule
